// ----- rtl/core/txcon_pkg.sv -----
// Shared types and constants of the text console engine.
// No dependencies; every other file of the block imports this package.
package txcon_pkg;

   // Payload field widths
   localparam int CMD_W      = 1;
   localparam int CHAR_W     = 8;
   localparam int ATTR_W     = 8;
   localparam int ROW_FLD_W  = 5;
   localparam int COL_FLD_W  = 7;
   localparam int CELL_W     = CHAR_W + ATTR_W;

   // Register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_ATTRIBUTE = 2'd2;

   localparam logic [ROW_FLD_W-1:0] ROW_COUNT_RST = 5'd25;
   localparam logic [COL_FLD_W-1:0] COL_COUNT_RST = 7'd80;
   localparam logic [ATTR_W-1:0]    RESET_ATTR    = 8'd7;

   // Commands
   localparam logic [CMD_W-1:0] CMD_PUT  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

   // Special character codes
   localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CODE_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'd32;

   // Controller to datapath
   typedef struct packed {
      logic clr_step;   // one step of the power-up blanking sweep
      logic exec;       // item accepted: run put or issue read
      logic copy_rd;    // scroll: read source cell
      logic copy_wr;    // scroll: write it one row up
      logic blank;      // scroll: blank one cell of the last row
      logic load_rsp;   // load result register
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clr_last;
      logic need_scroll;
      logic rows_one;
      logic copy_last;
      logic blank_last;
   } dp_status_type;

endpackage

// ----- rtl/core/txcon_ctrl.sv -----
// Sequencer of the text console engine: blanking sweep, put/read, scroll.
// Depends on txcon_pkg; drives the command struct of txcon_dp.
module txcon_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [txcon_pkg::CMD_W-1:0]  req_command,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output txcon_pkg::dp_cmd_type        dp_cmd,
   input  txcon_pkg::dp_status_type     dp_status
);
   import txcon_pkg::*;

   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_COPY_RD = 3'd2;
   localparam logic [2:0] ST_COPY_WR = 3'd3;
   localparam logic [2:0] ST_BLANK   = 3'd4;
   localparam logic [2:0] ST_FIN     = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      case (state_ff)
         ST_CLEAR: begin
            dp_cmd.clr_step = 1'b1;
            if (dp_status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               dp_cmd.exec = 1'b1;
               if (req_command == CMD_READ || !dp_status.need_scroll) begin
                  state_in = ST_FIN;
               end else if (dp_status.rows_one) begin
                  state_in = ST_BLANK;
               end else begin
                  state_in = ST_COPY_RD;
               end
            end
         end
         ST_COPY_RD: begin
            dp_cmd.copy_rd = 1'b1;
            state_in       = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            dp_cmd.copy_wr = 1'b1;
            state_in       = dp_status.copy_last ? ST_BLANK : ST_COPY_RD;
         end
         ST_BLANK: begin
            dp_cmd.blank = 1'b1;
            if (dp_status.blank_last) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (slot_free) begin
               dp_cmd.load_rsp = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result only appears out of the finishing state
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result raised outside finish state");

   // An accepted item always takes the engine out of idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("accepted item did not occupy the engine");

endmodule

// ----- rtl/core/txcon_dp.sv -----
// Datapath of the text console engine: cell store, cursor, scroll counters,
// register file and result register. Depends on txcon_pkg; driven by txcon_ctrl.
module txcon_dp #(
   parameter int MAX_ROWS    = 25,
   parameter int MAX_COLUMNS = 80
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [txcon_pkg::CMD_W-1:0]       req_command,
   input  logic [txcon_pkg::CHAR_W-1:0]      req_char_code,
   input  logic [txcon_pkg::ROW_FLD_W-1:0]   req_read_row,
   input  logic [txcon_pkg::COL_FLD_W-1:0]   req_read_column,
   input  logic                              csr_write_enable,
   input  logic [txcon_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [txcon_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  txcon_pkg::dp_cmd_type             dp_cmd,
   output txcon_pkg::dp_status_type          dp_status,
   output logic [txcon_pkg::CHAR_W-1:0]      rsp_cell_char,
   output logic [txcon_pkg::ATTR_W-1:0]      rsp_cell_attr,
   output logic [txcon_pkg::COL_FLD_W-1:0]   rsp_cursor_column,
   output logic [txcon_pkg::ROW_FLD_W-1:0]   rsp_cursor_row,
   output logic                              rsp_scrolled
);
   import txcon_pkg::*;

   localparam int Depth    = MAX_ROWS * MAX_COLUMNS;
   localparam int AddrW    = $clog2(Depth);
   localparam int RowW     = $clog2(MAX_ROWS);
   localparam int ColW     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int RowCntW  = $clog2(MAX_ROWS + 1);
   localparam int ColCntW  = $clog2(MAX_COLUMNS + 1);
   localparam int CmpW     = ((RowCntW > ColCntW) ? RowCntW : ColCntW) + 1;

   function automatic logic [AddrW-1:0] cell_addr(input logic [RowW-1:0] r,
                                                  input logic [ColW-1:0] c);
      return AddrW'(r * MAX_COLUMNS) + AddrW'(c);
   endfunction

   // Cell store
   logic [CELL_W-1:0] screen_ff [Depth];
   logic [CELL_W-1:0] rd_data_ff;
   logic              mem_we, mem_re;
   logic [AddrW-1:0]  mem_waddr, mem_raddr;
   logic [CELL_W-1:0] mem_wdata;

   // Registers
   logic [ROW_FLD_W-1:0] row_count_ff, row_count_in;
   logic [COL_FLD_W-1:0] col_count_ff, col_count_in;
   logic [ATTR_W-1:0]    attr_ff, attr_in;
   logic [RowW-1:0]      cur_row_ff, cur_row_in;
   logic [ColW-1:0]      cur_col_ff, cur_col_in;
   logic [RowW-1:0]      sc_row_ff, sc_row_in;
   logic [ColW-1:0]      sc_col_ff, sc_col_in;
   logic [AddrW-1:0]     clr_addr_ff, clr_addr_in;
   logic                 is_read_ff, is_read_in;
   logic                 rd_ok_ff, rd_ok_in;
   logic                 scrolled_ff, scrolled_in;
   logic [CHAR_W-1:0]    cell_char_ff, cell_char_in;
   logic [ATTR_W-1:0]    cell_attr_ff, cell_attr_in;
   logic [COL_FLD_W-1:0] out_col_ff, out_col_in;
   logic [ROW_FLD_W-1:0] out_row_ff, out_row_in;
   logic                 out_scr_ff, out_scr_in;

   logic [RowCntW-1:0] eff_rows;
   logic [ColCntW-1:0] eff_cols;
   logic [CmpW-1:0]    col_inc, row_next, sc_col_inc, sc_row_inc2;
   logic               is_cr, is_lf, wrap, need_scroll, sc_col_end, rd_in_range;
   logic [RowW-1:0]    last_row;

   // Saturated counts
   always_comb begin
      if (row_count_ff == '0) eff_rows = RowCntW'(1);
      else if (32'(row_count_ff) > MAX_ROWS) eff_rows = RowCntW'(MAX_ROWS);
      else eff_rows = RowCntW'(row_count_ff);
      if (col_count_ff == '0) eff_cols = ColCntW'(1);
      else if (32'(col_count_ff) > MAX_COLUMNS) eff_cols = ColCntW'(MAX_COLUMNS);
      else eff_cols = ColCntW'(col_count_ff);
   end

   // Cursor advance for a put
   assign is_cr       = (req_char_code == CODE_CR);
   assign is_lf       = (req_char_code == CODE_LF);
   assign col_inc     = CmpW'(cur_col_ff) + CmpW'(1);
   assign wrap        = (col_inc >= CmpW'(eff_cols));
   assign row_next    = CmpW'(cur_row_ff) + CmpW'(is_lf || (!is_cr && wrap));
   assign need_scroll = !is_cr && (row_next >= CmpW'(eff_rows));
   assign last_row    = RowW'(eff_rows - RowCntW'(1));

   // Scroll sweep
   assign sc_col_inc  = CmpW'(sc_col_ff) + CmpW'(1);
   assign sc_col_end  = (sc_col_inc >= CmpW'(eff_cols));
   assign sc_row_inc2 = CmpW'(sc_row_ff) + CmpW'(2);

   assign rd_in_range = (32'(req_read_row) < MAX_ROWS) && (32'(req_read_column) < MAX_COLUMNS);

   assign dp_status.clr_last    = (clr_addr_ff == AddrW'(Depth - 1));
   assign dp_status.need_scroll = need_scroll;
   assign dp_status.rows_one    = (eff_rows == RowCntW'(1));
   assign dp_status.copy_last   = sc_col_end && (sc_row_inc2 >= CmpW'(eff_rows));
   assign dp_status.blank_last  = sc_col_end;

   // Memory port selection
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = '0;
      if (dp_cmd.clr_step) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = {RESET_ATTR, BLANK_CHAR};
      end else if (dp_cmd.exec) begin
         if (req_command == CMD_READ) begin
            mem_re    = rd_in_range;
            mem_raddr = cell_addr(RowW'(req_read_row), ColW'(req_read_column));
         end else if (!is_cr && !is_lf) begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(cur_row_ff, cur_col_ff);
            mem_wdata = {attr_ff, req_char_code};
         end
      end else if (dp_cmd.copy_rd) begin
         mem_re    = 1'b1;
         mem_raddr = cell_addr(RowW'(sc_row_ff + 1'b1), sc_col_ff);
      end else if (dp_cmd.copy_wr) begin
         mem_we    = 1'b1;
         mem_waddr = cell_addr(sc_row_ff, sc_col_ff);
         mem_wdata = rd_data_ff;
      end else if (dp_cmd.blank) begin
         mem_we    = 1'b1;
         mem_waddr = cell_addr(last_row, sc_col_ff);
         mem_wdata = {attr_ff, BLANK_CHAR};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) screen_ff[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= screen_ff[mem_raddr];
   end

   // Next-state logic
   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      attr_in      = attr_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      sc_row_in    = sc_row_ff;
      sc_col_in    = sc_col_ff;
      clr_addr_in  = clr_addr_ff;
      is_read_in   = is_read_ff;
      rd_ok_in     = rd_ok_ff;
      scrolled_in  = scrolled_ff;
      cell_char_in = cell_char_ff;
      cell_attr_in = cell_attr_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_scr_in   = out_scr_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_ROW_COUNT:      row_count_in = csr_write_data[ROW_FLD_W-1:0];
            CSR_COLUMN_COUNT:   col_count_in = csr_write_data[COL_FLD_W-1:0];
            CSR_TEXT_ATTRIBUTE: attr_in      = csr_write_data[ATTR_W-1:0];
            default: ;
         endcase
      end

      if (dp_cmd.clr_step) clr_addr_in = clr_addr_ff + AddrW'(1);

      if (dp_cmd.exec) begin
         is_read_in = (req_command == CMD_READ);
         rd_ok_in   = rd_in_range;
         if (req_command == CMD_READ) begin
            scrolled_in = 1'b0;
         end else begin
            scrolled_in = need_scroll;
            sc_row_in   = '0;
            sc_col_in   = '0;
            cur_col_in  = (is_cr || is_lf || wrap) ? '0 : ColW'(col_inc);
            cur_row_in  = need_scroll ? last_row : RowW'(row_next);
         end
      end

      if (dp_cmd.copy_wr) begin
         if (sc_col_end) begin
            sc_col_in = '0;
            sc_row_in = sc_row_ff + RowW'(1);
         end else begin
            sc_col_in = ColW'(sc_col_inc);
         end
      end

      if (dp_cmd.blank) sc_col_in = sc_col_end ? '0 : ColW'(sc_col_inc);

      if (dp_cmd.load_rsp) begin
         cell_char_in = (is_read_ff && rd_ok_ff) ? rd_data_ff[CHAR_W-1:0] : '0;
         cell_attr_in = (is_read_ff && rd_ok_ff) ? rd_data_ff[CELL_W-1:CHAR_W] : '0;
         out_col_in   = COL_FLD_W'(cur_col_ff);
         out_row_in   = ROW_FLD_W'(cur_row_ff);
         out_scr_in   = scrolled_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= ROW_COUNT_RST;
         col_count_ff <= COL_COUNT_RST;
         attr_ff      <= RESET_ATTR;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         clr_addr_ff  <= '0;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         attr_ff      <= attr_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         clr_addr_ff  <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      sc_row_ff    <= sc_row_in;
      sc_col_ff    <= sc_col_in;
      is_read_ff   <= is_read_in;
      rd_ok_ff     <= rd_ok_in;
      scrolled_ff  <= scrolled_in;
      cell_char_ff <= cell_char_in;
      cell_attr_ff <= cell_attr_in;
      out_col_ff   <= out_col_in;
      out_row_ff   <= out_row_in;
      out_scr_ff   <= out_scr_in;
   end

   assign rsp_cell_char     = cell_char_ff;
   assign rsp_cell_attr     = cell_attr_ff;
   assign rsp_cursor_column = out_col_ff;
   assign rsp_cursor_row    = out_row_ff;
   assign rsp_scrolled      = out_scr_ff;

   // Cursor always points into the store
   a_cursor_in_store: assert property (@(posedge clock) disable iff (reset)
      (32'(cur_col_ff) < MAX_COLUMNS) && (32'(cur_row_ff) < MAX_ROWS))
      else $error("cursor outside cell store");

   // A scrolling put parks the cursor on the last used row; the column keeps
   // its advance when the row was already past a shrunken window
   a_scroll_last_row: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.exec && req_command == CMD_PUT && need_scroll) |=>
         (cur_row_ff == last_row))
      else $error("cursor not on last row after scroll");

   // A read leaves the cursor alone
   a_read_keeps_cursor: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.exec && req_command == CMD_READ) |=>
         $stable(cur_col_ff) && $stable(cur_row_ff))
      else $error("read moved the cursor");

endmodule

// ----- rtl/core/text_console_cursor_scroll_unit.sv -----
// Text console engine: character/attribute cell store with cursor and scroll.
// Depends on txcon_pkg, txcon_ctrl and txcon_dp.
//
// The unit holds a MAX_ROWS x MAX_COLUMNS store of 16-bit cells (attribute in
// the upper byte, character in the lower) in a single memory with one write
// and one registered read port, and a cursor. A put item handles one byte:
// carriage return homes the column, line feed homes the column and moves down
// a row, any other byte is stored at the cursor with the current attribute and
// the cursor advances, wrapping at the column count. Moving past the last used
// row scrolls the screen up one row and blanks the last row. A read item
// returns one cell; addresses outside the store read as zero. Every item gives
// exactly one result, which also reports the cursor and whether a scroll took
// place. An item ends in the finishing state, which loads the result register
// once it is free. A scrolling put, with rows the effective row count, copies
// the cells of rows 1 to rows-1 up one row, each read and then written through
// the memory port, then blanks the last row one cell per cycle. After reset a
// blanking sweep fills all MAX_ROWS*MAX_COLUMNS cells with spaces in attribute
// 7; items are held off during the sweep, register writes are taken throughout.
// One item is in work at a time; the result register lets the next item be
// taken while a result waits on rsp_stall. Registers: index 0 row_count,
// 1 column_count, 2 text_attribute; write them only while the unit is idle.
module text_console_cursor_scroll_unit #(
   parameter int MAX_ROWS    = 25,
   parameter int MAX_COLUMNS = 80
) (
   input  logic                              clock,
   input  logic                              reset,
   // item in
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [txcon_pkg::CMD_W-1:0]       req_command,
   input  logic [txcon_pkg::CHAR_W-1:0]      req_char_code,
   input  logic [txcon_pkg::ROW_FLD_W-1:0]   req_read_row,
   input  logic [txcon_pkg::COL_FLD_W-1:0]   req_read_column,
   // result out
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [txcon_pkg::CHAR_W-1:0]      rsp_cell_char,
   output logic [txcon_pkg::ATTR_W-1:0]      rsp_cell_attr,
   output logic [txcon_pkg::COL_FLD_W-1:0]   rsp_cursor_column,
   output logic [txcon_pkg::ROW_FLD_W-1:0]   rsp_cursor_row,
   output logic                              rsp_scrolled,
   // register writes
   input  logic                              csr_write_enable,
   input  logic [txcon_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [txcon_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import txcon_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Sequencer: sweep, accept, scroll loop, result hand-off
   txcon_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status)
   );

   // Store, cursor, registers and result register
   txcon_dp #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_command       (req_command),
      .req_char_code     (req_char_code),
      .req_read_row      (req_read_row),
      .req_read_column   (req_read_column),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .dp_cmd            (dp_cmd),
      .dp_status         (dp_status),
      .rsp_cell_char     (rsp_cell_char),
      .rsp_cell_attr     (rsp_cell_attr),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_scrolled      (rsp_scrolled)
   );

endmodule
